FILE: src/sart_pkg.sv
// Shared types and constants for the selective-ack receive tracker.
`timescale 1ns / 1ps

package sart_pkg;

  localparam int SEQ_W    = 32;
  localparam int STREAM_W = 2;
  localparam int MASK_W   = 24;
  localparam int LOW_W    = 8;
  localparam int HIGH_W   = 2;

  localparam logic [STREAM_W-1:0] ACK_STREAM_RESET = STREAM_W'(1);

  typedef enum logic [0:0] {
    OP_RECEIVE = 1'b0,
    OP_ACK     = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [STREAM_W-1:0] stream_select;
    logic [SEQ_W-1:0]    sequence_number;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  delivered_count;
    logic [LOW_W-1:0]  ack_seq_low;
    logic [HIGH_W-1:0] ack_seq_high;
    logic [MASK_W-1:0] ack_mask;
    logic              window_overflow;
  } out_item_t;

endpackage

FILE: src/sart_chan_if.sv
// Valid/ready channel carrying one transaction payload.
`timescale 1ns / 1ps

interface sart_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/sart_advance.sv
// Trailing-ones advance: finds the run of received numbers and shifts it out.
`timescale 1ns / 1ps

module sart_advance #(
  parameter int WINDOW = 64
) (
  input  logic [WINDOW-1:0]             bitmap_in,
  output logic [$clog2(WINDOW+1)-1:0]   shift_amt,
  output logic [WINDOW-1:0]             bitmap_out
);
  localparam int CW = $clog2(WINDOW+1);

  logic [WINDOW:0] ext;
  logic [WINDOW:0] plus_one;
  logic [WINDOW:0] first_zero;

  // lowest clear bit isolated as a one-hot: ~x & (x+1)
  assign ext        = {1'b0, bitmap_in};
  assign plus_one   = ext + (WINDOW+1)'(1);
  assign first_zero = ~ext & plus_one;

  always_comb begin
    shift_amt = '0;
    for (int j = 0; j <= WINDOW; j++) begin
      if (first_zero[j]) begin
        shift_amt = shift_amt | CW'(j);
      end
    end
  end

  assign bitmap_out = bitmap_in >> shift_amt;

endmodule

FILE: src/selective_ack_receive_tracker.sv
// Selective-ack receive tracker: per-stream in-order counters and ahead bitmaps.
`timescale 1ns / 1ps
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      opcode, stream_select, sequence_number
//  out_chan  out  valid/ready      delivered_count, ack_seq_low/high, ack_mask,
//                                  window_overflow
//  cfg_*     in   write enable     ack_stream (2 bits)
//
//  One transaction per cycle sustained while out_chan.ready holds; a result
//  passes the input register, then the result register, on its way to
//  out_chan. The work sits between those two registers: a 32-bit distance
//  subtract, a WINDOW+1 bit increment to find the trailing-ones run, a barrel
//  shift and a 32-bit counter add.
//  Reset (rst_n low, synchronous) zeroes all counters and bitmaps and sets
//  ack_stream to 1; no clearing pass is needed.
//  A stalled result register holds the input register, which in turn drops
//  in_chan.ready; state is only updated when a result is written.

module selective_ack_receive_tracker #(
  parameter int NUM_STREAMS = 3,
  parameter int WINDOW      = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sart_chan_if.sink                     in_chan,
  sart_chan_if.source                   out_chan,
  input  logic                          cfg_wr_en,
  input  logic [sart_pkg::STREAM_W-1:0] cfg_wr_data
);
  import sart_pkg::*;

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int PW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW+1);

  // configuration
  logic [STREAM_W-1:0] ack_stream_r;

  // per-stream state
  logic [SEQ_W-1:0]  counter_r [NUM_STREAMS];
  logic [WINDOW-1:0] bitmap_r  [NUM_STREAMS];

  // input and result registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic s1_go;

  // stream lookup
  logic [STREAM_W-1:0] rd_stream;
  logic [3:0]          rd_wide;
  logic [SW-1:0]       rd_idx;
  logic                stream_ok;
  logic [SEQ_W-1:0]    cur_cnt;
  logic [WINDOW-1:0]   cur_bm;

  // receive path
  logic [SEQ_W-1:0]  seq_gap;
  logic [SEQ_W-1:0]  seq_gap_m1;
  logic              in_win;
  logic              beyond;
  logic [WINDOW-1:0] marked_bm;
  logic [CW-1:0]     shift_amt;
  logic [WINDOW-1:0] shifted_bm;
  logic [SEQ_W-1:0]  new_cnt;
  logic              upd;

  // handshake: input register moves on when the result register is free
  assign s1_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_stream_r <= ACK_STREAM_RESET;
    end else if (cfg_wr_en) begin
      ack_stream_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r <= in_chan.data;
    end
  end

  // one read port: ack reads the configured stream, receive the selected one
  assign rd_stream = (s1_item_r.opcode == OP_ACK) ? ack_stream_r : s1_item_r.stream_select;
  assign rd_wide   = {2'b00, rd_stream};
  assign rd_idx    = rd_wide[SW-1:0];
  assign stream_ok = rd_wide < 4'(NUM_STREAMS);

  always_comb begin
    cur_cnt = '0;
    cur_bm  = '0;
    for (int s = 0; s < NUM_STREAMS; s++) begin
      if (rd_idx == SW'(s)) begin
        cur_cnt = counter_r[s];
        cur_bm  = bitmap_r[s];
      end
    end
  end

  // modular distance; 1..WINDOW marks, 0 or the upper half is stale
  assign seq_gap    = s1_item_r.sequence_number - cur_cnt;
  assign seq_gap_m1 = seq_gap - SEQ_W'(1);
  assign in_win     = (seq_gap != '0) && (seq_gap <= SEQ_W'(WINDOW));
  assign beyond     = !in_win && (seq_gap != '0) && !seq_gap[SEQ_W-1];

  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      marked_bm[j] = cur_bm[j] | (in_win && (seq_gap_m1[PW-1:0] == PW'(j)));
    end
  end

  sart_advance #(
    .WINDOW (WINDOW)
  ) u_advance (
    .bitmap_in  (marked_bm),
    .shift_amt  (shift_amt),
    .bitmap_out (shifted_bm)
  );

  assign new_cnt = cur_cnt + SEQ_W'(shift_amt);
  assign upd     = s1_go && (s1_item_r.opcode == OP_RECEIVE) && stream_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STREAMS; s++) begin
        counter_r[s] <= '0;
        bitmap_r[s]  <= '0;
      end
    end else if (upd) begin
      for (int s = 0; s < NUM_STREAMS; s++) begin
        if (rd_idx == SW'(s)) begin
          counter_r[s] <= new_cnt;
          bitmap_r[s]  <= shifted_bm;
        end
      end
    end
  end

  // result build; an out-of-range stream gives an all-zero transaction
  always_comb begin
    out_item_nxt = '0;
    if (stream_ok) begin
      if (s1_item_r.opcode == OP_RECEIVE) begin
        out_item_nxt.delivered_count = new_cnt;
        out_item_nxt.window_overflow = beyond;
      end else begin
        out_item_nxt.delivered_count = cur_cnt;
        out_item_nxt.ack_seq_low     = cur_cnt[LOW_W-1:0];
        out_item_nxt.ack_seq_high    = cur_cnt[LOW_W+HIGH_W-1:LOW_W];
        out_item_nxt.ack_mask        = cur_bm[MASK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

FILE: test/selective_ack_receive_tracker_tb.sv
// Self-checking testbench for the selective-ack receive tracker.
`timescale 1ns / 1ps

module selective_ack_receive_tracker_tb;
  import sart_pkg::*;

  localparam int NUM_STREAMS = 3;
  localparam int WINDOW      = 64;
  localparam int PHASE_ITEMS = 130;  // counted transactions per random phase
  localparam int LONG_HOLD   = 300;  // receiver hold-off, in cycles
  localparam int SETTLE      = 4;    // two-stage pipe plus margin

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en;
  logic [STREAM_W-1:0] cfg_wr_data;

  sart_chan_if #(.data_t(in_item_t))  in_chan_if ();
  sart_chan_if #(.data_t(out_item_t)) out_chan_if ();

  selective_ack_receive_tracker #(
    .NUM_STREAMS(NUM_STREAMS),
    .WINDOW     (WINDOW)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan_if),
    .out_chan   (out_chan_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timeout: far beyond the slowest legal run (~1k transactions with stalls).
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tracker model: per-stream in-order counter and ahead bitmap, plus the
  // ack-stream register. Bit i of the bitmap stands for counter+1+i.
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0]    model_count [NUM_STREAMS];
  logic [WINDOW-1:0]   model_ahead [NUM_STREAMS];
  logic [STREAM_W-1:0] model_ack_stream;

  out_item_t expected_results [$];
  in_item_t  packets_to_send [$];

  int mismatches   = 0;
  int results_seen = 0;

  // Work out the result of one accepted transaction and update the model.
  function automatic out_item_t advance_tracker(in_item_t item);
    out_item_t        res;
    logic [SEQ_W-1:0] seq_gap;
    logic [SEQ_W-1:0] cnt;
    int               s;
    res = '0;
    if (item.opcode == OP_RECEIVE) begin
      // Streams beyond the configured count leave state alone, result all zero.
      if (item.stream_select < NUM_STREAMS) begin
        s    = item.stream_select;
        // Serial-number distance, modulo 2^32.
        seq_gap = item.sequence_number - model_count[s];
        if (seq_gap >= 1 && seq_gap <= WINDOW) begin
          model_ahead[s][seq_gap - 1] = 1'b1;
          // Deliver the run of consecutive numbers now present.
          while (model_ahead[s][0]) begin
            model_count[s] = model_count[s] + 1;
            model_ahead[s] = model_ahead[s] >> 1;
          end
        end else if (seq_gap != 0 && !seq_gap[SEQ_W-1]) begin
          // Ahead but past the window: dropped and flagged.
          res.window_overflow = 1'b1;
        end
        // gap of 0 or in the upper half is old/duplicate: silently ignored.
        res.delivered_count = model_count[s];
      end
    end else if (model_ack_stream < NUM_STREAMS) begin
      cnt                 = model_count[model_ack_stream];
      res.delivered_count = cnt;
      res.ack_seq_low     = cnt[7:0];
      res.ack_seq_high    = cnt[9:8];
      res.ack_mask        = model_ahead[model_ack_stream][MASK_W-1:0];
    end
    return res;
  endfunction

  // Model follows the config port and every accepted input transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (model_count[i]) begin
        model_count[i] = '0;
        model_ahead[i] = '0;
      end
      model_ack_stream = ACK_STREAM_RESET;
    end else begin
      if (cfg_wr_en) model_ack_stream = cfg_wr_data;
      if (in_chan_if.valid && in_chan_if.ready)
        expected_results.push_back(advance_tracker(in_chan_if.data));
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.delivered_count !== want.delivered_count)
      flag_mismatch($sformatf("result %0d delivered_count got %0h want %0h",
                              results_seen, got.delivered_count, want.delivered_count));
    if (got.ack_seq_low !== want.ack_seq_low)
      flag_mismatch($sformatf("result %0d ack_seq_low got %0h want %0h",
                              results_seen, got.ack_seq_low, want.ack_seq_low));
    if (got.ack_seq_high !== want.ack_seq_high)
      flag_mismatch($sformatf("result %0d ack_seq_high got %0h want %0h",
                              results_seen, got.ack_seq_high, want.ack_seq_high));
    if (got.ack_mask !== want.ack_mask)
      flag_mismatch($sformatf("result %0d ack_mask got %06h want %06h",
                              results_seen, got.ack_mask, want.ack_mask));
    if (got.window_overflow !== want.window_overflow)
      flag_mismatch($sformatf("result %0d window_overflow got %0b want %0b",
                              results_seen, got.window_overflow, want.window_overflow));
  endtask

  // Monitor. results_seen is updated nonblocking so the receiver reads a
  // settled value at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0)
        flag_mismatch($sformatf("result with nothing outstanding: %p", out_chan_if.data));
      else
        compare_result(out_chan_if.data, expected_results.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. A gap of zero
  // gives back-to-back bursts, so long unbroken stretches occur too.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_chan_if.valid || in_chan_if.ready) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (burst_left > 0 && packets_to_send.size() > 0) begin
        in_chan_if.data  <= packets_to_send.pop_front();
        in_chan_if.valid <= 1'b1;
        burst_left--;
      end else begin
        in_chan_if.valid <= 1'b0;
        if (burst_left == 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern picked afresh at regular steps of rx_cycle. Twice
  // during the run it holds ready low for a LONG_HOLD stretch so the pipe fills
  // and in_chan.ready drops while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int          stall_mode;
  int          hold_left;
  int          holds_done;
  int unsigned rx_cycle;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan_if.ready <= 1'b0;
      rx_cycle   = 0;
      stall_mode = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < 2 && results_seen >= 150 + 450 * holds_done) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_chan_if.ready <= 1'b1;
          1:       out_chan_if.ready <= $urandom_range(0, 1);
          2:       out_chan_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan_if.ready <= rx_cycle[1];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own view of the next fresh
  // sequence number per stream and emits every number, reordered within
  // short runs, so counters keep advancing. Noise goes in on top.
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0] gen_next       [NUM_STREAMS];
  logic [SEQ_W-1:0] gen_late       [NUM_STREAMS];
  bit               gen_late_valid [NUM_STREAMS];
  int               items_queued = 0;

  task automatic queue_item(opcode_t op, logic [STREAM_W-1:0] sel, logic [SEQ_W-1:0] seq);
    in_item_t item;
    item.opcode          = op;
    item.stream_select   = sel;
    item.sequence_number = seq;
    packets_to_send.push_back(item);
    // Receives on an absent stream are ignored by the block; don't count them.
    if (op == OP_ACK || sel < NUM_STREAMS) items_queued++;
  endtask

  // One run of fresh numbers on stream s, shuffled. Sometimes one number is
  // held back to the next run on the stream, sometimes one is repeated. A
  // rare wide run spans the whole window with its first number sent last.
  task automatic queue_run(int s);
    logic [SEQ_W-1:0] nums [$];
    logic [SEQ_W-1:0] tmp;
    bit               wide;
    int               n;
    int               k;
    int               j;
    int               idx;
    wide = !gen_late_valid[s] && ($urandom_range(0, 29) == 0);
    n    = wide ? WINDOW : $urandom_range(1, 12);
    for (k = 1; k <= n; k++) nums.push_back(gen_next[s] + k);
    gen_next[s] = gen_next[s] + n;
    if (wide) tmp = nums.pop_front();
    for (k = nums.size() - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      idx     = nums[k];
      nums[k] = nums[j];
      nums[j] = idx;
    end
    if (wide) begin
      nums.push_back(tmp);
    end else if (gen_late_valid[s]) begin
      nums.push_back(gen_late[s]);
      gen_late_valid[s] = 1'b0;
    end else if (n > 1 && $urandom_range(0, 3) == 0) begin
      idx               = $urandom_range(0, n - 1);
      gen_late[s]       = nums[idx];
      gen_late_valid[s] = 1'b1;
      nums.delete(idx);
    end
    if ($urandom_range(0, 7) == 0) nums.push_back(nums[$urandom_range(0, nums.size() - 1)]);
    foreach (nums[i]) queue_item(OP_RECEIVE, STREAM_W'(s), nums[i]);
  endtask

  task automatic run_random_phase(int target);
    int stop;
    int pick;
    int s;
    stop = items_queued + target;
    while (items_queued < stop) begin
      pick = $urandom_range(0, 99);
      // Stream 1 gets half the traffic so its counter climbs furthest.
      case ($urandom_range(0, 3))
        0:       s = 0;
        3:       s = 2;
        default: s = 1;
      endcase
      if (pick < 60)
        queue_run(s);
      else if (pick < 75)
        queue_item(OP_ACK, STREAM_W'($urandom_range(0, 3)), $urandom());
      else if (pick < 85)   // just past the window
        queue_item(OP_RECEIVE, STREAM_W'(s), gen_next[s] + $urandom_range(WINDOW + 1, 5000));
      else if (pick < 92)   // old or duplicate
        queue_item(OP_RECEIVE, STREAM_W'(s), gen_next[s] - $urandom_range(0, 200));
      else if (pick < 97)
        queue_item(OP_RECEIVE, STREAM_W'($urandom_range(0, 3)), $urandom());
      else
        queue_item(OP_RECEIVE, STREAM_W'(3), $urandom());
    end
  endtask

  // Register write, done only while the block is idle.
  task automatic write_ack_stream(logic [STREAM_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Everything sent and checked, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    while (packets_to_send.size() > 0 || in_chan_if.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  logic [STREAM_W-1:0] phase_ack [6] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0};

  initial begin
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_chan_if.valid  = 1'b0;
    in_chan_if.data   = '0;
    out_chan_if.ready = 1'b0;
    foreach (gen_next[i]) gen_late_valid[i] = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, acks reporting stream 1.
    write_ack_stream(2'd1);
    queue_item(OP_ACK,     2'd3, 32'hffff_ffff);  // fresh state, ack fields ignored
    queue_item(OP_RECEIVE, 2'd1, 32'd3);          // ahead of counter
    queue_item(OP_RECEIVE, 2'd1, 32'd3);          // duplicate ahead
    queue_item(OP_RECEIVE, 2'd1, 32'd0);          // distance zero
    queue_item(OP_RECEIVE, 2'd1, 32'd64);         // last slot of the window
    queue_item(OP_RECEIVE, 2'd1, 32'd65);         // first past the window
    queue_item(OP_RECEIVE, 2'd1, 32'hffff_ffff);  // behind, by wrap
    queue_item(OP_RECEIVE, 2'd1, 32'h7fff_ffff);  // largest forward distance
    queue_item(OP_RECEIVE, 2'd1, 32'h8000_0000);  // half range: treated as old
    queue_item(OP_ACK,     2'd0, 32'd0);
    queue_item(OP_RECEIVE, 2'd1, 32'd1);          // in order
    queue_item(OP_RECEIVE, 2'd1, 32'd2);          // closes gap, run to 3
    queue_item(OP_ACK,     2'd2, 32'd5);
    queue_item(OP_RECEIVE, 2'd1, 32'd27);         // top bit of the ack mask
    queue_item(OP_RECEIVE, 2'd1, 32'd4);
    queue_item(OP_ACK,     2'd1, 32'h1234_5678);
    queue_item(OP_RECEIVE, 2'd3, 32'd1);          // absent stream
    queue_item(OP_RECEIVE, 2'd0, 32'hffff_ffff);
    queue_item(OP_RECEIVE, 2'd0, 32'd1);
    queue_item(OP_RECEIVE, 2'd2, 32'd2);
    queue_item(OP_RECEIVE, 2'd2, 32'd1);
    queue_item(OP_RECEIVE, 2'd2, 32'd0);
    wait_idle();

    // Generator picks up where the directed numbers left off.
    gen_next[0] = 32'd1;
    gen_next[1] = 32'd4;
    gen_next[2] = 32'd2;

    // Random phases, each under the ack-stream setting from phase_ack (3 = absent).
    foreach (phase_ack[p]) begin
      write_ack_stream(phase_ack[p]);
      run_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
